### hdl/wplm_pkg.sv
// ============================================================================
// wplm_pkg - shared types and constants of the windowed power level meter
// Field widths, the register map and the fixed-point constants of the level
// computation.
// ============================================================================
`default_nettype none

package wplm_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int FRAC_BITS    = SAMPLE_BITS - 1;
	localparam int POS_BITS     = 12;
	localparam int LEVEL_BITS   = 16;
	localparam int CFG_BITS     = 13;
	localparam int CHAN_BITS    = 4;
	localparam int MAX_BUFFER   = 4096;
	localparam int MAX_CHANNELS = 8;

	// Shared bit-serial multiplier operand width.
	localparam int MUL_W = 32;

	// log2 result: integer part of a 64-bit argument, 16 fraction bits.
	localparam int LOG_INT_W  = 6;
	localparam int LOG_FRAC_W = 16;
	localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;

	// Signed log difference and its magnitude.
	localparam int DIFF_W = 24;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_WINDOW_SIZE   = 2'd0,
		REG_BUFFER_LENGTH = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} reg_index_t;

	// Minimum power of 0.000125 in units of 2^-(2*FRAC_BITS).
	localparam logic [63:0] MIN_POWER = (64'd1 << (2 * FRAC_BITS)) / 64'd8000;

	// 256 * 10 * log10(2) in Q16.
	localparam logic [MUL_W-1:0] DB_PER_OCTAVE_Q16 = 32'd50504453;

	// Scale offset of the squared Q1.23 samples, in Q16 octaves.
	localparam logic signed [DIFF_W-1:0] LOG_OFFSET = DIFF_W'(2 * FRAC_BITS * 65536);

	localparam logic signed [31:0] LEVEL_MIN = -32'sd24000;
	localparam logic signed [31:0] LEVEL_MAX = 32'sd0;

	// Request to the bit-serial multiplier.
	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

### hdl/wplm_if.sv
// ============================================================================
// wplm_if - valid/ready channels of the windowed power level meter
// One interface carries input items, the other carries level results.
// ============================================================================
`default_nettype none

interface wplm_in_if;
	import wplm_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic        [POS_BITS-1:0]    position;
	logic                          buffer_end;

	modport source (output valid, output sample, output position, output buffer_end,
		input ready);
	modport sink (input valid, input sample, input position, input buffer_end,
		output ready);
endinterface

interface wplm_out_if;
	import wplm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [LEVEL_BITS-1:0] level_db;

	modport source (output valid, output level_db, input ready);
	modport sink (input valid, input level_db, output ready);
endinterface

`default_nettype wire

### hdl/wplm_serial_mul.sv
// ============================================================================
// wplm_serial_mul - bit-serial unsigned multiplier
// Shift-add multiplier that retires one bit of operand b per cycle and needs
// only a MUL_W-bit adder.
// ============================================================================
`default_nettype none

module wplm_serial_mul
	import wplm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mul_req_t           req,
	output logic                    done,
	output logic [2*MUL_W-1:0]      prod
);

	localparam int CNT_W = $clog2(MUL_W);

	logic [MUL_W-1:0] a_q;
	logic [MUL_W-1:0] hi_q;
	logic [MUL_W-1:0] lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MUL_W:0]   psum;

	assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(MUL_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// The partial sum shifts down into the low half as the multiplier bits retire.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			lo_q <= req.b;
			hi_q <= '0;
		end else if (busy_q) begin
			hi_q <= psum[MUL_W:1];
			lo_q <= {psum[0], lo_q[MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

### hdl/wplm_log2.sv
// ============================================================================
// wplm_log2 - sequential base-2 logarithm
// Normalizes a 64-bit value one bit per cycle, then finds 16 fraction bits
// by repeated squaring of the 32-bit mantissa on a bit-serial multiplier.
// ============================================================================
`default_nettype none

module wplm_log2
	import wplm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [63:0]      x,
	output logic                  done,
	output logic [LOG_W-1:0]      result
);

	typedef enum logic [1:0] {
		L_IDLE,
		L_NORM,
		L_SQ,
		L_WAIT
	} lstate_t;

	lstate_t                 state_q;
	logic [63:0]             w_q;
	logic [LOG_INT_W-1:0]    n_q;
	logic [MUL_W-1:0]        y_q;
	logic [LOG_FRAC_W-1:0]   frac_q;
	logic [3:0]              it_q;
	logic                    done_q;
	logic [LOG_W-1:0]        res_q;
	mul_req_t                mul_req_q;
	logic                    mul_done;
	logic [2*MUL_W-1:0]      mul_prod;
	logic [LOG_FRAC_W-1:0]   frac_next;

	wplm_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// The top product bit says whether the squared mantissa reached two.
	assign frac_next = {frac_q[LOG_FRAC_W-2:0], mul_prod[2*MUL_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			done_q    <= 1'b0;
			res_q     <= '0;
			mul_req_q <= '0;
			w_q       <= '0;
			n_q       <= '0;
			y_q       <= '0;
			frac_q    <= '0;
			it_q      <= '0;
		end else begin
			done_q          <= 1'b0;
			mul_req_q.start <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						if (x == 64'd0) begin
							res_q  <= '0;
							done_q <= 1'b1;
						end else begin
							w_q     <= x;
							n_q     <= LOG_INT_W'(63);
							state_q <= L_NORM;
						end
					end
				end
				L_NORM: begin
					if (w_q[63]) begin
						y_q     <= w_q[63:32];
						frac_q  <= '0;
						it_q    <= '0;
						state_q <= L_SQ;
					end else begin
						w_q <= {w_q[62:0], 1'b0};
						n_q <= n_q - 1'b1;
					end
				end
				L_SQ: begin
					mul_req_q <= '{start: 1'b1, a: y_q, b: y_q};
					state_q   <= L_WAIT;
				end
				L_WAIT: begin
					if (mul_done) begin
						y_q    <= mul_prod[2*MUL_W-1] ? mul_prod[2*MUL_W-1:MUL_W]
							: mul_prod[2*MUL_W-2:MUL_W-1];
						frac_q <= frac_next;
						if (it_q == 4'd15) begin
							res_q   <= {n_q, frac_next};
							done_q  <= 1'b1;
							state_q <= L_IDLE;
						end else begin
							it_q    <= it_q + 1'b1;
							state_q <= L_SQ;
						end
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

### hdl/windowed_power_level_meter_top.sv
// ============================================================================
// windowed_power_level_meter_top - RMS level meter in 1/256 dB
// Sums the squares of the samples in each channel's trailing window and, at
// each buffer end, reports 10*log10 of the sum over length times channels.
// ============================================================================
// Usage:
// Samples enter on in_ch, channel after channel, each with its position in
// the buffer; buffer_end marks the last sample of the last channel. Only that
// item produces a result, one level_db on out_ch.
// A sample inside the window is squared on a bit-serial multiplier, one bit
// per cycle, and the block takes no new item until the square is in the sum;
// a sample outside the window needs no multiply and leaves the block ready for
// the next item. The end-of-buffer item runs two logarithms and the scaling
// multiply on the serial units; each logarithm normalizes its argument and
// then squares its mantissa 16 times. The result waits in an output register:
// a stalled receiver does not stop the block from taking the next buffer's
// samples; it only holds the next end-of-buffer item before its result is
// written. Reset clears the sum, drops any pending result and loads the
// register defaults (window 128, buffer length 128, one channel).
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle; the block does not enforce this.
// ============================================================================
`default_nettype none

module windowed_power_level_meter_top
	import wplm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [CFG_BITS-1:0]  cfg_data,
	wplm_in_if.sink                   in_ch,
	wplm_out_if.source                out_ch
);

	typedef enum logic [3:0] {
		T_IDLE,
		T_SQ_WAIT,
		T_ACC,
		T_LOG_SUM,
		T_LOG_SUM_WAIT,
		T_LOG_DIV_WAIT,
		T_SCALE_WAIT,
		T_ROUND,
		T_EMIT
	} tstate_t;

	tstate_t                    state_q;
	logic [CFG_BITS-1:0]        window_q;
	logic [CFG_BITS-1:0]        length_q;
	logic [CHAN_BITS-1:0]       chan_q;
	logic [63:0]                sum_q;
	logic                       last_q;
	logic [LOG_W-1:0]           ls_q;
	logic                       neg_q;
	logic signed [63:0]         p_q;
	logic signed [LEVEL_BITS-1:0] lvl_q;
	logic                       out_valid_q;
	logic signed [LEVEL_BITS-1:0] level_q;
	mul_req_t                   mul_req_q;
	logic                       log_start_q;
	logic [63:0]                log_x_q;

	logic                       mul_done;
	logic [2*MUL_W-1:0]         mul_prod;
	logic                       log_done;
	logic [LOG_W-1:0]           log_res;

	logic [CFG_BITS-1:0]        len_eff;
	logic [CHAN_BITS-1:0]       chan_eff;
	logic [CFG_BITS-1:0]        win_start;
	logic                       in_win;
	logic [SAMPLE_BITS-1:0]     mag;
	logic [CFG_BITS+CHAN_BITS-1:0] divisor;
	logic [64:0]                sum_next;
	logic [63:0]                sum_floor;
	logic signed [DIFF_W-1:0]   l_diff;
	logic [DIFF_W-1:0]          l_abs;
	logic signed [63:0]         p_round;
	logic signed [31:0]         q_lvl;
	logic                       accept;
	logic                       out_free;

	wplm_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	wplm_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start_q),
		.x      (log_x_q),
		.done   (log_done),
		.result (log_res)
	);

	// Zero lengths and channel counts count as one, oversized ones clamp to the maximum.
	always_comb begin
		if (length_q == '0) begin
			len_eff = CFG_BITS'(1);
		end else if (length_q > CFG_BITS'(MAX_BUFFER)) begin
			len_eff = CFG_BITS'(MAX_BUFFER);
		end else begin
			len_eff = length_q;
		end
		if (chan_q == '0) begin
			chan_eff = CHAN_BITS'(1);
		end else if (chan_q > CHAN_BITS'(MAX_CHANNELS)) begin
			chan_eff = CHAN_BITS'(MAX_CHANNELS);
		end else begin
			chan_eff = chan_q;
		end
	end

	assign win_start = (len_eff > window_q) ? (len_eff - window_q) : '0;
	assign in_win    = ({1'b0, in_ch.position} >= win_start)
		&& ({1'b0, in_ch.position} < len_eff);
	assign mag       = in_ch.sample[SAMPLE_BITS-1] ? (~in_ch.sample + 1'b1) : in_ch.sample;
	assign divisor   = (CFG_BITS+CHAN_BITS)'(chan_eff) * (CFG_BITS+CHAN_BITS)'(len_eff);

	assign sum_next  = {1'b0, sum_q} + {1'b0, mul_prod};
	assign sum_floor = (sum_q < MIN_POWER) ? MIN_POWER : sum_q;

	assign l_diff = $signed({2'b00, ls_q}) - $signed({2'b00, log_res}) - LOG_OFFSET;
	assign l_abs  = l_diff[DIFF_W-1] ? (~l_diff + 1'b1) : l_diff;

	// Round to the nearest 1/256 dB, halves up.
	assign p_round = p_q + 64'sd2147483648;
	assign q_lvl   = p_round[63:32];

	assign in_ch.ready = (state_q == T_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= CFG_BITS'(128);
			length_q <= CFG_BITS'(128);
			chan_q   <= CHAN_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SIZE:   window_q <= cfg_data;
				REG_BUFFER_LENGTH: length_q <= cfg_data;
				REG_CHANNEL_COUNT: chan_q   <= cfg_data[CHAN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			sum_q       <= '0;
			last_q      <= 1'b0;
			mul_req_q   <= '0;
			log_start_q <= 1'b0;
			log_x_q     <= '0;
			ls_q        <= '0;
			neg_q       <= 1'b0;
			p_q         <= '0;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
		end else begin
			mul_req_q.start <= 1'b0;
			log_start_q     <= 1'b0;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						last_q <= in_ch.buffer_end;
						if (in_win) begin
							mul_req_q <= '{start: 1'b1, a: MUL_W'(mag), b: MUL_W'(mag)};
							state_q   <= T_SQ_WAIT;
						end else if (in_ch.buffer_end) begin
							state_q <= T_LOG_SUM;
						end
					end
				end
				T_SQ_WAIT: begin
					if (mul_done) begin
						state_q <= T_ACC;
					end
				end
				T_ACC: begin
					sum_q   <= sum_next[64] ? {64{1'b1}} : sum_next[63:0];
					state_q <= last_q ? T_LOG_SUM : T_IDLE;
				end
				T_LOG_SUM: begin
					log_start_q <= 1'b1;
					log_x_q     <= sum_floor;
					state_q     <= T_LOG_SUM_WAIT;
				end
				T_LOG_SUM_WAIT: begin
					if (log_done) begin
						ls_q        <= log_res;
						log_start_q <= 1'b1;
						log_x_q     <= 64'(divisor);
						state_q     <= T_LOG_DIV_WAIT;
					end
				end
				T_LOG_DIV_WAIT: begin
					if (log_done) begin
						neg_q     <= l_diff[DIFF_W-1];
						mul_req_q <= '{start: 1'b1, a: DB_PER_OCTAVE_Q16, b: MUL_W'(l_abs)};
						sum_q     <= '0;
						state_q   <= T_SCALE_WAIT;
					end
				end
				T_SCALE_WAIT: begin
					if (mul_done) begin
						p_q     <= neg_q ? -$signed(mul_prod) : $signed(mul_prod);
						state_q <= T_ROUND;
					end
				end
				T_ROUND: begin
					if (q_lvl < LEVEL_MIN) begin
						lvl_q <= LEVEL_MIN[LEVEL_BITS-1:0];
					end else if (q_lvl > LEVEL_MAX) begin
						lvl_q <= LEVEL_MAX[LEVEL_BITS-1:0];
					end else begin
						lvl_q <= q_lvl[LEVEL_BITS-1:0];
					end
					state_q <= T_EMIT;
				end
				T_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						level_q     <= lvl_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.level_db = level_q;

endmodule

`default_nettype wire

### hdl/wplm_checker.sv
// ============================================================================
// wplm_checker - port-level checks of the windowed power level meter
// Watches the top-level channels and flags out-of-range levels, results that
// appear while idle, ready after buffer_end and stalled results that change.
// ============================================================================
`default_nettype none

module wplm_checker
	import wplm_pkg::*;
(
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         in_buffer_end,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [LEVEL_BITS-1:0] out_level_db
);

	// Every level lies in the saturation range.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_level_db >= LEVEL_MIN) && (out_level_db <= LEVEL_MAX))
		else $error("level_db out of range");

	// An end-of-buffer item always leaves the block busy in the cycle after it is taken.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_buffer_end |=> !in_ready)
		else $error("input ready right after an end-of-buffer item");

	// A new result is only written while the input side is closed.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level_db))
		else $error("stalled result changed");

endmodule

bind windowed_power_level_meter_top wplm_checker u_wplm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_buffer_end (in_ch.buffer_end),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_level_db  (out_ch.level_db)
);

`default_nettype wire
